@@ rtl/i2a_pkg.sv @@
// Shared types and constants for the integer to ASCII radix converter.
package i2a_pkg;

    // Radix selector codes; the unused code converts as decimal
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_BIN = 2'd2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;   // '0'
    localparam logic [7:0] CHAR_A     = 8'h61;   // 'a'
    localparam logic [7:0] CHAR_MINUS = 8'h2d;   // '-'
    localparam logic [3:0] DEC_BASE   = 4'd10;

    // Largest number of characters sent for one conversion
    localparam int unsigned RESULT_LIMIT = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXTRACT,
        ST_SIZE,
        ST_EMIT,
        ST_EMPTY
    } i2a_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture a new operand
        logic step;       // one digit extraction step
        logic size;       // work out padding, length and count
        logic advance;    // a character transaction completed
        logic show_empty; // present the empty result
    } i2a_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic extract_done; // final digit written this cycle
        logic none_fits;    // nothing to send for this conversion
        logic last_char;    // current character is the final one
    } i2a_status_t;

endpackage

@@ rtl/i2a_ctrl.sv @@
// Sequencing state machine for the integer to ASCII radix converter.
module i2a_ctrl
    import i2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output i2a_cmd_t    cmd,
    input  i2a_status_t status
);

    i2a_state_t state_reg;
    i2a_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXTRACT;
                end
            end
            ST_EXTRACT:
            begin
                if (status.extract_done)
                begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                state_next = status.none_fits ? ST_EMPTY : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (m_tready && status.last_char)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMPTY:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready       = 1'b0;
        m_tvalid       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_EXTRACT:
            begin
                cmd.step = 1'b1;
            end
            ST_SIZE:
            begin
                cmd.size = 1'b1;
            end
            ST_EMIT:
            begin
                m_tvalid    = 1'b1;
                cmd.advance = m_tready;
            end
            ST_EMPTY:
            begin
                m_tvalid       = 1'b1;
                cmd.show_empty = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/i2a_datapath.sv @@
// Digit extraction, digit store and character formatting for the converter.
module i2a_datapath
    import i2a_pkg::*;
#(
    parameter int MAX_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] value,
    input  logic        signed_mode,
    input  logic [1:0]  radix_select,
    input  logic [5:0]  min_chars,
    input  logic [15:0] capacity,
    input  i2a_cmd_t    cmd,
    output i2a_status_t status,
    output logic [7:0]  out_char,
    output logic        char_valid,
    output logic        last,
    output logic [5:0]  full_length
);

    localparam logic [6:0] MAXW = 7'(MAX_WIDTH);

    // Operand and conversion settings
    logic [31:0] rv_reg, rv_next;
    logic        neg_reg;
    logic [1:0]  rsel_reg;
    logic [5:0]  minw_reg;
    logic [15:0] cap_reg;

    // Decimal division runs as two 16-bit halves per digit
    logic        half_reg;
    logic [15:0] hiq_reg;
    logic [3:0]  rem_reg;

    logic [5:0]  dc_reg;
    logic [5:0]  emit_reg;
    logic [5:0]  n_reg;
    logic [5:0]  pad_reg;
    logic [5:0]  flen_reg;
    logic [3:0]  store_reg [32];

    // Division step
    logic [19:0] div_in;
    logic [39:0] div_prod;
    logic [15:0] div_q;
    logic [19:0] div_back;
    logic [3:0]  div_r;

    logic        is_hex, is_bin;
    logic        digit_wr;
    logic [3:0]  digit;

    // Sizing
    logic [5:0]  sum_len;
    logic [5:0]  pad_c;
    logic [5:0]  total_c;
    logic [15:0] room;
    logic [5:0]  n_c;

    // Formatting
    logic [5:0]  sign_pad;
    logic [5:0]  pos;
    logic [5:0]  idx;
    logic [3:0]  rd_digit;

    assign is_hex = (rsel_reg == RADIX_HEX);
    assign is_bin = (rsel_reg == RADIX_BIN);

    // v / 10 by reciprocal; exact for v below 10 * 2^16
    assign div_in   = half_reg ? {rem_reg, rv_reg[15:0]} : {4'd0, rv_reg[31:16]};
    assign div_prod = 40'(div_in) * 40'd838861;
    assign div_q    = div_prod[38:23];
    assign div_back = {div_q, 3'b000} + {3'b000, div_q, 1'b0};
    assign div_r    = 4'(div_in - div_back);

    always_comb
    begin
        rv_next  = rv_reg;
        digit_wr = 1'b0;
        digit    = 4'd0;
        priority if (is_hex)
        begin
            digit    = rv_reg[3:0];
            rv_next  = {4'd0, rv_reg[31:4]};
            digit_wr = 1'b1;
        end
        else if (is_bin)
        begin
            digit    = {3'd0, rv_reg[0]};
            rv_next  = {1'b0, rv_reg[31:1]};
            digit_wr = 1'b1;
        end
        else if (half_reg)
        begin
            digit    = div_r;
            rv_next  = {hiq_reg, div_q};
            digit_wr = 1'b1;
        end
        else
        begin
            digit_wr = 1'b0;
        end
    end

    assign status.extract_done = cmd.step && digit_wr && (rv_next == 32'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= 1'b0;
            dc_reg   <= '0;
            emit_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                half_reg <= 1'b0;
                dc_reg   <= '0;
            end
            else if (cmd.step)
            begin
                if (!is_hex && !is_bin)
                begin
                    half_reg <= ~half_reg;
                end
                if (digit_wr)
                begin
                    dc_reg <= dc_reg + 6'd1;
                end
            end
            if (cmd.size)
            begin
                emit_reg <= '0;
            end
            else if (cmd.advance)
            begin
                emit_reg <= emit_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg  <= signed_mode & value[31];
            rv_reg   <= (signed_mode & value[31]) ? (32'd0 - value) : value;
            rsel_reg <= radix_select;
            minw_reg <= ({1'b0, min_chars} > MAXW) ? MAXW[5:0] : min_chars;
            cap_reg  <= capacity;
        end
        else if (cmd.step)
        begin
            if (digit_wr)
            begin
                rv_reg                 <= rv_next;
                store_reg[dc_reg[4:0]] <= digit;
            end
            else
            begin
                hiq_reg <= div_q;
                rem_reg <= div_r;
            end
        end
        if (cmd.size)
        begin
            n_reg    <= n_c;
            pad_reg  <= pad_c;
            flen_reg <= total_c;
        end
    end

    // Length: sign, zero padding up to the minimum width, then digits
    always_comb
    begin
        sum_len = dc_reg + {5'd0, neg_reg};
        pad_c   = (minw_reg > sum_len) ? (minw_reg - sum_len) : 6'd0;
        total_c = sum_len + pad_c;
        room    = (cap_reg == 16'd0) ? 16'd0 : (cap_reg - 16'd1);
        n_c     = (room > 16'(total_c)) ? total_c : room[5:0];
        if (n_c > 6'(RESULT_LIMIT))
        begin
            n_c = 6'(RESULT_LIMIT);
        end
    end

    assign status.none_fits = (n_c == 6'd0);
    assign status.last_char = (emit_reg + 6'd1 == n_reg);

    // Character at the current position, most significant first
    assign sign_pad = {5'd0, neg_reg} + pad_reg;
    assign pos      = emit_reg - sign_pad;
    assign idx      = dc_reg - 6'd1 - pos;
    assign rd_digit = store_reg[idx[4:0]];

    always_comb
    begin
        out_char    = 8'd0;
        char_valid  = 1'b1;
        last        = status.last_char;
        full_length = flen_reg;
        if (cmd.show_empty)
        begin
            char_valid = 1'b0;
            last       = 1'b1;
        end
        else if (emit_reg < {5'd0, neg_reg})
        begin
            out_char = CHAR_MINUS;
        end
        else if (emit_reg < sign_pad)
        begin
            out_char = CHAR_ZERO;
        end
        else if (rd_digit < DEC_BASE)
        begin
            out_char = CHAR_ZERO + {4'd0, rd_digit};
        end
        else
        begin
            out_char = CHAR_A + {4'd0, rd_digit - DEC_BASE};
        end
    end

endmodule

@@ rtl/integer_to_ascii_radix_core.sv @@
// Top level of the integer to ASCII radix converter.
//
// One input transaction carries a 32-bit operand with its signed flag and
// radix (tuser), a minimum width and the destination capacity (tdata). The
// block answers with one output transaction per character, most significant
// first, tlast on the final one; every character carries the full text
// length. When no character fits, one transaction with the char flag low is
// sent instead.
// Sequence: accept, then digit extraction (hex and binary one digit per
// step, decimal through a reciprocal divide-by-ten on 16-bit halves, high
// half then low half for each digit), a sizing step, then the characters
// in order.
// Conversions run one at a time; s_tready is high only between conversions.
// A stall on m_tready holds the current character and its fields stable.
// Reset returns the sequencer to idle and drops m_tvalid; the digit store
// needs no clearing.
module integer_to_ascii_radix_core
    import i2a_pkg::*;
#(
    parameter int MAX_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // value[31:0], min_chars[37:32], capacity[53:38]
    input  logic [2:0]  s_tuser,  // signed_mode[0], radix_select[2:1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // out_char[7:0], full_length[13:8]
    output logic        m_tuser,  // char_valid
    output logic        m_tlast
);

    i2a_cmd_t    cmd;
    i2a_status_t status;
    logic [7:0]  out_char;
    logic [5:0]  full_length;

    i2a_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    i2a_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (s_tdata[31:0]),
        .signed_mode  (s_tuser[0]),
        .radix_select (s_tuser[2:1]),
        .min_chars    (s_tdata[37:32]),
        .capacity     (s_tdata[53:38]),
        .cmd          (cmd),
        .status       (status),
        .out_char     (out_char),
        .char_valid   (m_tuser),
        .last         (m_tlast),
        .full_length  (full_length)
    );

    assign m_tdata = {2'b00, full_length, out_char};

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the integer to ASCII radix converter.
module tb_top;
    import i2a_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH_CAP      = 32;
    localparam int RANDOM_ITEMS   = 440;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AFTER     = 300;   // characters seen before the long hold
    localparam int TAIL_CYCLES    = 80;
    localparam logic [1:0] RADIX_SPARE = 2'd3;

    typedef struct packed {
        logic [31:0] value;
        logic        signed_mode;
        logic [1:0]  radix_select;
        logic [5:0]  min_chars;
        logic [15:0] capacity;
    } conv_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       last;
        logic [5:0] full_length;
    } char_result_t;

    // flen below zero: row is checked against the predictor
    typedef struct {
        conv_item_t item;
        string      text;
        int         flen;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;   // value[31:0], min_chars[37:32], capacity[53:38]
    logic [2:0]  s_tuser = '0;   // signed_mode[0], radix_select[2:1]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // out_char[7:0], full_length[13:8]
    logic        m_tuser;        // char_valid
    logic        m_tlast;

    char_result_t  pending_chars[$];
    directed_row_t directed_rows[$];
    int            errors = 0;
    int            chars_seen = 0;
    int            quiet_cycles = 0;

    integer_to_ascii_radix_core #(.MAX_WIDTH(WIDTH_CAP)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the characters of one conversion and queues them
    function automatic void predict_text(input conv_item_t it);
        logic [3:0]  digits [32];
        logic [31:0] mag;
        int unsigned base;
        int unsigned ndig;
        int unsigned sign_len;
        int unsigned minw;
        int unsigned pad;
        int unsigned total;
        int unsigned flen;
        int unsigned n;
        int unsigned pos;
        bit          neg;
        char_result_t res;

        base = (it.radix_select == RADIX_HEX) ? 16 :
               (it.radix_select == RADIX_BIN) ? 2 : DEC_BASE;
        neg = it.signed_mode && it.value[31];
        sign_len = neg ? 1 : 0;
        mag = neg ? (32'd0 - it.value) : it.value;
        minw = (it.min_chars > WIDTH_CAP) ? WIDTH_CAP : it.min_chars;

        ndig = 0;
        if (mag == 0)
        begin
            digits[0] = 4'd0;
            ndig = 1;
        end
        while (mag != 0 && ndig < 32)
        begin
            digits[ndig] = 4'(mag % base);
            mag = mag / base;
            ndig++;
        end

        pad = (minw > ndig + sign_len) ? minw - ndig - sign_len : 0;
        total = sign_len + pad + ndig;
        flen = (total > 63) ? 63 : total;
        n = (it.capacity > 0) ? it.capacity - 1 : 0;
        if (n > total)
            n = total;
        if (n > RESULT_LIMIT)
            n = RESULT_LIMIT;

        if (n == 0)
        begin
            res = '{out_char: 8'd0, char_valid: 1'b0, last: 1'b1, full_length: 6'(flen)};
            pending_chars.push_back(res);
            return;
        end

        for (int unsigned k = 0; k < n; k++)
        begin
            if (k < sign_len)
                res.out_char = CHAR_MINUS;
            else if (k < sign_len + pad)
                res.out_char = CHAR_ZERO;
            else
            begin
                pos = ndig - 1 - (k - sign_len - pad);
                res.out_char = (digits[pos] < 10) ? CHAR_ZERO + 8'(digits[pos])
                                                  : CHAR_A + 8'(digits[pos]) - 8'd10;
            end
            res.char_valid = 1'b1;
            res.last = (k + 1 == n);
            res.full_length = 6'(flen);
            pending_chars.push_back(res);
        end
    endfunction

    function automatic directed_row_t conv_row(input logic [31:0] v, input int sgn,
                                               input logic [1:0] rsel, input int w,
                                               input int c, input string text,
                                               input int flen);
        directed_row_t rw;
        rw.item = '{value: v, signed_mode: 1'(sgn), radix_select: rsel, min_chars: 6'(w),
                    capacity: 16'(c)};
        rw.text = text;
        rw.flen = flen;
        return rw;
    endfunction

    // Mostly short gaps, a few long ones, and whole stretches with none
    function automatic int pick_gap(input int idx);
        int roll;
        roll = $urandom_range(0, 99);
        if ((idx / 40) % 3 == 0 || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_conversion(input conv_item_t it, input int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {2'b00, it.capacity, it.min_chars, it.value};
        s_tuser  <= {it.radix_select, it.signed_mode};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Sender
    initial
    begin
        conv_item_t    it;
        directed_row_t rw;
        int            sel;

        directed_rows.push_back(conv_row(32'h0000_0000, 0, RADIX_DEC, 0, 100, "0", 1));
        directed_rows.push_back(conv_row(32'hFFFF_FFFF, 0, RADIX_DEC, 0, 100, "4294967295", 10));
        directed_rows.push_back(conv_row(32'hFFFF_FFFF, 1, RADIX_DEC, 0, 100, "-1", 2));
        directed_rows.push_back(conv_row(32'h8000_0000, 1, RADIX_DEC, 0, 100, "-2147483648", 11));
        directed_rows.push_back(conv_row(32'h8000_0000, 1, RADIX_HEX, 0, 100, "-80000000", 9));
        directed_rows.push_back(conv_row(32'h8000_0000, 1, RADIX_BIN, 0, 100, "", -1));
        directed_rows.push_back(conv_row(32'hFFFF_FFFF, 0, RADIX_BIN, 0, 65535, "", -1));
        directed_rows.push_back(conv_row(32'hDEAD_BEEF, 0, RADIX_HEX, 0, 100, "deadbeef", 8));
        directed_rows.push_back(conv_row(32'h7FFF_FFFF, 1, RADIX_DEC, 0, 100, "2147483647", 10));
        directed_rows.push_back(conv_row(32'd12345, 0, RADIX_SPARE, 0, 100, "12345", 5));
        // nothing fits
        directed_rows.push_back(conv_row(32'd42, 0, RADIX_DEC, 0, 0, "", 2));
        directed_rows.push_back(conv_row(32'hFFFF_FFFF, 0, RADIX_DEC, 0, 1, "", 10));
        directed_rows.push_back(conv_row(32'd987, 0, RADIX_DEC, 0, 2, "9", 3));
        directed_rows.push_back(conv_row(32'd42, 0, RADIX_DEC, 8, 100, "00000042", 8));
        directed_rows.push_back(conv_row(32'hFFFF_FFD6, 1, RADIX_DEC, 8, 100, "-0000042", 8));
        // minimum width beyond the cap saturates
        directed_rows.push_back(conv_row(32'd5, 0, RADIX_HEX, 63, 100, "", -1));
        directed_rows.push_back(conv_row(32'hFFFF_FFFF, 1, RADIX_BIN, 40, 100, "", -1));
        directed_rows.push_back(conv_row(32'd0, 0, RADIX_DEC, 32, 65535, "", -1));
        directed_rows.push_back(conv_row(32'd7, 0, RADIX_DEC, 10, 5, "0000", 10));
        directed_rows.push_back(conv_row(32'h1234_ABCD, 1, RADIX_HEX, 0, 100, "1234abcd", 8));
        directed_rows.push_back(conv_row(32'hFFFF_FFFB, 1, RADIX_DEC, 0, 2, "-", 2));
        directed_rows.push_back(conv_row(32'd0, 0, RADIX_BIN, 1, 100, "0", 1));
        directed_rows.push_back(conv_row(32'd5, 0, RADIX_BIN, 0, 100, "101", 3));
        directed_rows.push_back(conv_row(32'hFFFF_FFFF, 1, RADIX_HEX, 0, 65535, "-1", 2));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < directed_rows.size(); i++)
        begin
            rw = directed_rows[i];
            send_conversion(rw.item, pick_gap(i));
            if (rw.flen < 0)
                predict_text(rw.item);
            else if (rw.text.len() == 0)
                pending_chars.push_back('{out_char: 8'd0, char_valid: 1'b0, last: 1'b1,
                                          full_length: 6'(rw.flen)});
            else
                for (int k = 0; k < rw.text.len(); k++)
                    pending_chars.push_back('{out_char: rw.text[k], char_valid: 1'b1,
                                              last: (k == rw.text.len() - 1),
                                              full_length: 6'(rw.flen)});
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            sel = $urandom_range(0, 7);
            if (sel == 0)
                it.value = $urandom_range(0, 20);
            else if (sel == 1)
                it.value = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                                : 32'hFFFF_FFFF - $urandom_range(0, 3);
            else
                it.value = $urandom;
            it.signed_mode  = 1'($urandom_range(0, 1));
            it.radix_select = 2'($urandom_range(0, 3));
            it.min_chars    = 6'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 12)
                                                            : $urandom_range(0, 63));
            sel = $urandom_range(0, 9);
            if (sel == 0)
                it.capacity = 16'($urandom_range(0, 1));
            else if (sel < 4)
                it.capacity = 16'($urandom_range(2, 12));
            else if (sel < 8)
                it.capacity = 16'($urandom_range(13, 40));
            else
                it.capacity = 16'($urandom_range(0, 65535));
            send_conversion(it, pick_gap(i));
            predict_text(it);
        end
        s_tvalid <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && pending_chars.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stalls, quiet stretches, and one long hold-off
    int          rx_cycle = 0;
    int          stall_left = 0;
    bit          hold_done = 1'b0;
    int unsigned rx_roll;

    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        rx_roll = $urandom_range(0, 99);
        if (!rst_n)
            m_tready <= 1'b0;
        else if (!hold_done && chars_seen >= HOLD_AFTER)
        begin
            hold_done  <= 1'b1;
            stall_left <= LONG_HOLD;
            m_tready   <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (rx_cycle[9:7] == 3'd0 || rx_roll < 70)
            m_tready <= 1'b1;
        else
        begin
            m_tready   <= 1'b0;
            stall_left <= (rx_roll < 95) ? $urandom_range(0, 3) : $urandom_range(8, 40);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        char_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            chars_seen <= chars_seen + 1;
            if (pending_chars.size() == 0)
            begin
                $error("unexpected result transaction: data %h user %b last %b",
                       m_tdata, m_tuser, m_tlast);
                errors++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (m_tdata[7:0] !== want.out_char)
                begin
                    $error("out_char: expected %h, got %h", want.out_char, m_tdata[7:0]);
                    errors++;
                end
                if (m_tuser !== want.char_valid)
                begin
                    $error("char_valid: expected %b, got %b", want.char_valid, m_tuser);
                    errors++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, m_tlast);
                    errors++;
                end
                if (m_tdata[13:8] !== want.full_length)
                begin
                    $error("full_length: expected %0d, got %0d", want.full_length,
                           m_tdata[13:8]);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
